/* src/dpd_pkg.sv */
// Shared types, character codes and helpers for the debug packet deframer.
`timescale 1ns / 1ps

package dpd_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h24;
  localparam logic [7:0] CH_CLOSE = 8'h23;
  localparam logic [7:0] CH_BREAK = 8'h03;

  typedef enum logic [1:0] {
    EV_BODY  = 2'd0,
    EV_GOOD  = 2'd1,
    EV_BAD   = 2'd2,
    EV_BREAK = 2'd3
  } ev_t;

  typedef struct packed {
    logic       valid;
    ev_t        ev;
    logic [7:0] body;
    logic       first;
  } dpd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one ASCII hex digit, either case; non-hex reads as zero.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* src/debug_packet_deframer_unit.sv */
// Top level of the debug packet deframer: input register, framing core, result register.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, in_rx_byte                | byte in
//  out     | out_valid, out_stall, out_event_res,          | event out
//          | out_body_byte, out_first_of_packet            |
//
// One byte per cycle sustained while the result side does not stall; a byte is held
// in the input register, then its result is registered in the result register.
// Bytes with no result still pass through the core and update its state.
// A stall on the result side backs up one byte in the input register, then
// raises in_stall. Reset clears the framing state to idle and empties both registers.
`timescale 1ns / 1ps

module debug_packet_deframer_unit
  import dpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_body_byte,
  output logic       out_first_of_packet
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  ev_t        out_ev_r;
  logic [7:0] out_body_r;
  logic       out_first_r;

  logic       advance;
  dpd_res_t   res;

  // Advance the held byte into the core when the result slot is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  dpd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_ev_r    <= res.ev;
      out_body_r  <= res.body;
      out_first_r <= res.first;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_ev_r;
  assign out_body_byte       = out_body_r;
  assign out_first_of_packet = out_first_r;

`ifndef ASSERT_OFF
  // A held byte is never overwritten while the core has not taken it.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (in_valid_r && $stable(in_byte_r)))
    else $error("held input byte lost");

  // Only body events carry a byte or the command flag.
  a_body_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_BODY) |-> (out_body_byte == 8'h00 && !out_first_of_packet))
    else $error("non-body event carries body data");

  // The core never steps while a stalled result still occupies the slot.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !advance)
    else $error("result overwritten while stalled");
`endif

endmodule

/* src/dpd_core.sv */
// Framing state machine: checksum accumulation and per-byte event decode.
`timescale 1ns / 1ps

module dpd_core
  import dpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output dpd_res_t   res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_CK1  = 2'd2,
    PH_CK2  = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [3:0] high_r, high_nxt;
  logic       high_ok_r, high_ok_nxt;
  logic       first_r, first_nxt;

  hex_t       hex;
  logic [7:0] ck_value;

  always_comb begin
    hex         = hex_decode(rx_byte);
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    high_nxt    = high_r;
    high_ok_nxt = high_ok_r;
    first_nxt   = first_r;
    ck_value    = 8'h00;
    res.valid   = 1'b0;
    res.ev      = EV_BODY;
    res.body    = 8'h00;
    res.first   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == CH_OPEN) begin
          phase_nxt = PH_BODY;
          sum_nxt   = 8'h00;
          first_nxt = 1'b1;
        end else if (rx_byte == CH_BREAK) begin
          res.valid = 1'b1;
          res.ev    = EV_BREAK;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_CLOSE) begin
          phase_nxt = PH_CK1;
        end else begin
          sum_nxt   = sum_r + rx_byte;
          first_nxt = 1'b0;
          res.valid = 1'b1;
          res.body  = rx_byte;
          res.first = first_r;
        end
      end
      PH_CK1: begin
        high_ok_nxt = hex.ok;
        high_nxt    = hex.val;
        phase_nxt   = PH_CK2;
      end
      PH_CK2: begin
        // Bad high digit zeroes the value; bad low digit keeps the high one alone.
        if (!high_ok_r) ck_value = 8'h00;
        else if (hex.ok) ck_value = {high_r, hex.val};
        else ck_value = {4'h0, high_r};
        phase_nxt = PH_IDLE;
        first_nxt = 1'b1;
        res.valid = 1'b1;
        res.ev    = (ck_value == sum_r) ? EV_GOOD : EV_BAD;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      sum_r     <= 8'h00;
      high_r    <= 4'h0;
      high_ok_r <= 1'b0;
      first_r   <= 1'b1;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      high_r    <= high_nxt;
      high_ok_r <= high_ok_nxt;
      first_r   <= first_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A closing byte in the body always lands on the first checksum digit.
  a_close_to_ck1: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_BODY && rx_byte == CH_CLOSE) |=> (phase_r == PH_CK1))
    else $error("close byte did not enter checksum phase");

  // The command-letter flag is set again whenever the block returns to idle.
  a_first_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_CK2) |=> (phase_r == PH_IDLE && first_r))
    else $error("command flag not rearmed after checksum");

  a_ck1_to_ck2: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_CK1) |=> (phase_r == PH_CK2))
    else $error("first checksum digit did not advance");
`endif

endmodule

/* tb/debug_packet_deframer_unit_tb.sv */
// Self-checking testbench for the debug packet deframer: framing predictor, driver and monitor.
`timescale 1ns / 1ps

module debug_packet_deframer_unit_tb
  import dpd_pkg::*;
;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;
  localparam int SETTLE      = 8;

  typedef enum logic [1:0] {
    FR_SCAN,
    FR_BODY,
    FR_SUM_HI,
    FR_SUM_LO
  } frame_phase_t;

  typedef struct {
    ev_t        ev;
    logic [7:0] body;
    logic       first;
  } link_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_event_res;
  logic [7:0] out_body_byte;
  logic       out_first_of_packet;

  debug_packet_deframer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_body_byte      (out_body_byte),
    .out_first_of_packet(out_first_of_packet)
  );

  always #10 clk = ~clk;

  // framing state of the predictor
  frame_phase_t fr_phase = FR_SCAN;
  logic [7:0]   body_sum = 8'h00;
  logic [3:0]   sum_hi = 4'h0;
  logic         sum_hi_ok = 1'b0;
  logic         want_cmd = 1'b1;

  logic [7:0]   rx_backlog [$];
  link_event_t  due_events [$];
  link_event_t  got_event;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic calm = 1'b0;
  logic hold_ask = 1'b0;
  logic hold_served = 1'b0;
  int   hold_cnt = 0;
  int   send_gap = 0;
  int   stall_gap = 0;
  int   idle_run = 0;
  int   fail_count = 0;
  int   items_queued = 0;
  int   bytes_in = 0;
  int   ev_seen [4] = '{0, 0, 0, 0};

  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] lc;
    lc = c | 8'h20;
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (lc >= "a" && lc <= "f") begin
      v = 4'(lc - 8'h57);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_event(input ev_t ev, input logic [7:0] body, input logic first);
    due_events.insert(due_events.size(), link_event_t'{ev, body, first});
  endfunction

  function automatic void deframe_byte(input logic [7:0] c);
    logic [3:0] d;
    logic [7:0] want;
    case (fr_phase)
      FR_SCAN: begin
        if (c == CH_OPEN) begin
          fr_phase = FR_BODY;
          body_sum = 8'h00;
          want_cmd = 1'b1;
        end else if (c == CH_BREAK) begin
          add_event(EV_BREAK, 8'h00, 1'b0);
        end
      end
      FR_BODY: begin
        if (c == CH_CLOSE) begin
          fr_phase = FR_SUM_HI;
        end else begin
          body_sum = body_sum + c;
          add_event(EV_BODY, c, want_cmd);
          want_cmd = 1'b0;
        end
      end
      FR_SUM_HI: begin
        sum_hi_ok = hex_digit(c, d);
        sum_hi = d;
        fr_phase = FR_SUM_LO;
      end
      default: begin
        // non-hex high digit zeroes the value; non-hex low digit leaves the high one alone
        if (!sum_hi_ok) begin
          want = 8'h00;
        end else if (hex_digit(c, d)) begin
          want = {sum_hi, d};
        end else begin
          want = {4'h0, sum_hi};
        end
        add_event((want == body_sum) ? EV_GOOD : EV_BAD, 8'h00, 1'b0);
        fr_phase = FR_SCAN;
        want_cmd = 1'b1;
      end
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] c);
    rx_backlog.insert(rx_backlog.size(), c);
    items_queued++;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + d;
    end
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (hex_digit(c, v));
    return c;
  endfunction

  task automatic send_packet(input int len);
    logic [7:0] b;
    logic [7:0] sum;
    int         pick;
    sum = 8'h00;
    queue_byte(CH_OPEN);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       b = CH_OPEN;
          1:       b = CH_BREAK;
          2:       b = 8'h00;
          default: b = 8'hFF;
        endcase
      end else begin
        do begin
          b = 8'($urandom_range(0, 255));
        end while (b == CH_CLOSE);
      end
      sum = sum + b;
      queue_byte(b);
    end
    queue_byte(CH_CLOSE);
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      queue_byte(hex_char(sum[7:4]));
      queue_byte(hex_char(sum[3:0]));
    end else if (pick < 15) begin
      sum = sum ^ 8'($urandom_range(1, 255));
      queue_byte(hex_char(sum[7:4]));
      queue_byte(hex_char(sum[3:0]));
    end else if (pick < 17) begin
      queue_byte(non_hex_char());
      queue_byte(8'($urandom_range(0, 255)));
    end else if (pick < 19) begin
      queue_byte(hex_char((sum < 8'd16) ? sum[3:0] : 4'($urandom_range(0, 15))));
      queue_byte(non_hex_char());
    end else begin
      // broken trailer: framing characters where the digits belong
      queue_byte(CH_OPEN);
      queue_byte(CH_CLOSE);
    end
  endtask

  task automatic queue_random(input int n);
    int         stop;
    logic [7:0] c;
    stop = items_queued + n;
    while (items_queued < stop) begin
      repeat ($urandom_range(0, 2)) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_BREAK) begin
          queue_byte(c);
        end else if (c != CH_OPEN) begin
          queue_byte(c);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        queue_byte(CH_BREAK);
      end
      send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6));
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
    end while (rx_backlog.size() != 0 || in_valid || due_events.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sender: hold a request until taken, otherwise advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 6);
      end else if (rx_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: one long hold on request, random short stalls otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_ask && !hold_served) begin
      hold_served <= 1'b1;
      hold_cnt <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      out_stall <= 1'b1;
      stall_gap <= stall_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_gap <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (in_taken) begin
      deframe_byte(in_rx_byte);
      bytes_in++;
    end
    if (out_taken) begin
      if (due_events.size() == 0) begin
        $error("unexpected result: event_res %0d body_byte %02h", out_event_res, out_body_byte);
        fail_count++;
      end else begin
        got_event = due_events.pop_front();
        ev_seen[got_event.ev]++;
        if (out_event_res !== got_event.ev) begin
          $error("event_res: expected %0d, got %0d", got_event.ev, out_event_res);
          fail_count++;
        end
        if (out_body_byte !== got_event.body) begin
          $error("body_byte: expected %02h, got %02h", got_event.body, out_body_byte);
          fail_count++;
        end
        if (out_first_of_packet !== got_event.first) begin
          $error("first_of_packet: expected %0b, got %0b", got_event.first,
                 out_first_of_packet);
          fail_count++;
        end
      end
    end
    if (in_taken || out_taken || !rst_n) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("debug_packet_deframer_unit: mismatch");
      $finish;
    end
  end

  initial begin
    logic [7:0] opening [$];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle noise and break, empty body, full-range body with in-body framing bytes,
    // non-hex high digit, non-hex low digit
    opening = {8'h00, 8'hFF, 8'h25, CH_BREAK,
               CH_OPEN, CH_CLOSE, "0", "0",
               CH_OPEN, "g", CH_OPEN, CH_BREAK, 8'hFF, 8'h00, CH_CLOSE, "8", "D",
               CH_OPEN, "m", CH_CLOSE, "Z", "5",
               CH_OPEN, 8'h0A, CH_CLOSE, "a", "G"};
    foreach (opening[i]) begin
      queue_byte(opening[i]);
    end
    drain();

    hold_ask = 1'b1;
    queue_random(360);
    drain();

    calm = 1'b1;
    queue_random(170);
    drain();

    $display("run covered %0d bytes: %0d body bytes, %0d good ends, %0d bad ends, %0d breaks",
             bytes_in, ev_seen[EV_BODY], ev_seen[EV_GOOD], ev_seen[EV_BAD],
             ev_seen[EV_BREAK]);
    if (fail_count == 0) begin
      $display("debug_packet_deframer_unit: match");
    end else begin
      $display("debug_packet_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dpd_pkg.sv
src/dpd_core.sv
src/debug_packet_deframer_unit.sv
tb/debug_packet_deframer_unit_tb.sv
